@@ rtl/ctbs_pkg.sv @@
`default_nettype none
package ctbs_pkg;

  localparam int NUM_TX_BUFFERS = 16;
  localparam int SCAN_W = (NUM_TX_BUFFERS > 1) ? $clog2(NUM_TX_BUFFERS) : 1;

  localparam int OPCODE_W = 3;
  localparam int BUF_IDX_W = 4;
  localparam int TX_ERR_W = 9;
  localparam int RX_ERR_W = 8;
  localparam int RX_OVF_W = 8;
  localparam int STATUS_W = 8;
  localparam int COUNT_W = 8;
  localparam int ERR_WORD_W = TX_ERR_W + RX_ERR_W + RX_OVF_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [TX_ERR_W-1:0] TX_BUSOFF_LIMIT = 9'd256;
  localparam logic [TX_ERR_W-1:0] TX_PASSIVE_LIMIT = 9'd128;
  localparam logic [TX_ERR_W-1:0] TX_WARN_LIMIT = 9'd96;
  localparam logic [RX_ERR_W-1:0] RX_PASSIVE_LIMIT = 8'd128;
  localparam logic [RX_ERR_W-1:0] RX_WARN_LIMIT = 8'd96;

  // error status bit positions
  localparam int ST_TXWARN = 0;
  localparam int ST_TXPASSIVE = 1;
  localparam int ST_BUSOFF = 2;
  localparam int ST_TXOVF = 3;
  localparam int ST_PDOLATE = 4;
  localparam int ST_RXWARN = 5;
  localparam int ST_RXPASSIVE = 6;
  localparam int ST_RXOVF = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SETUP    = 3'd0,
    OP_SEND     = 3'd1,
    OP_TX_DONE  = 3'd2,
    OP_CLR_SYNC = 3'd3,
    OP_ERR_UPD  = 3'd4
  } op_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [BUF_IDX_W-1:0] buffer_index;
    logic                 sync_flag;
    logic [TX_ERR_W-1:0]  tx_error_count;
    logic [RX_ERR_W-1:0]  rx_error_count;
    logic [RX_OVF_W-1:0]  rx_overflow_count;
  } in_item_t;

  typedef struct packed {
    logic                 transmit_valid;
    logic [BUF_IDX_W-1:0] transmit_index;
    logic                 send_overflow;
    logic [STATUS_W-1:0]  error_status;
    logic [COUNT_W-1:0]   pending_count;
  } result_t;

  typedef struct packed {
    logic              full_we;
    logic              full;
    logic              sync_we;
    logic              sync;
    logic [SCAN_W-1:0] addr;
  } flag_wr_t;

  typedef struct packed {
    logic full;
    logic sync;
  } flag_rd_t;

endpackage
`default_nettype wire

@@ rtl/ctbs_if.sv @@
`default_nettype none
interface ctbs_in_if import ctbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [BUF_IDX_W-1:0] buffer_index;
  logic                 sync_flag;
  logic [TX_ERR_W-1:0]  tx_error_count;
  logic [RX_ERR_W-1:0]  rx_error_count;
  logic [RX_OVF_W-1:0]  rx_overflow_count;

  modport source (
    output valid, opcode, buffer_index, sync_flag, tx_error_count, rx_error_count,
           rx_overflow_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, buffer_index, sync_flag, tx_error_count, rx_error_count,
           rx_overflow_count,
    output ready
  );
endinterface

interface ctbs_out_if import ctbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 transmit_valid;
  logic [BUF_IDX_W-1:0] transmit_index;
  logic                 send_overflow;
  logic [STATUS_W-1:0]  error_status;
  logic [COUNT_W-1:0]   pending_count;

  modport source (
    output valid, transmit_valid, transmit_index, send_overflow, error_status,
           pending_count,
    input  ready
  );
  modport sink (
    input  valid, transmit_valid, transmit_index, send_overflow, error_status,
           pending_count,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/ctbs_flags.sv @@
`default_nettype none
module ctbs_flags import ctbs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SCAN_W-1:0] rd_addr,
  output flag_rd_t               rd,
  input  wire flag_wr_t          wr
);

  logic [NUM_TX_BUFFERS-1:0] full_r;
  logic [NUM_TX_BUFFERS-1:0] sync_r;

  assign rd.full = full_r[rd_addr];
  assign rd.sync = sync_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      sync_r <= '0;
    end else begin
      if (wr.full_we) full_r[wr.addr] <= wr.full;
      if (wr.sync_we) sync_r[wr.addr] <= wr.sync;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ctbs_seq.sv @@
`default_nettype none
module ctbs_seq import ctbs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_item,
  input  wire logic              res_free,
  output logic                   res_valid,
  output result_t                res,
  output logic [SCAN_W-1:0]      rd_addr,
  input  wire flag_rd_t          rd,
  output flag_wr_t               wr
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic                  idx_ok_r, idx_ok_nxt;
  logic [SCAN_W-1:0]     scan_r, scan_nxt;
  logic [COUNT_W-1:0]    q_cnt_r, q_cnt_nxt;
  logic                  inhibit_r, inhibit_nxt;
  logic                  await_r, await_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [ERR_WORD_W-1:0] last_err_r, last_err_nxt;
  logic                  tvalid_r, tvalid_nxt;
  logic [BUF_IDX_W-1:0]  tidx_r, tidx_nxt;
  logic                  sovf_r, sovf_nxt;
  logic [ERR_WORD_W-1:0] err_word;
  logic [SCAN_W-1:0]     item_addr;
  logic                  scan_last;

  function automatic logic [STATUS_W-1:0] err_status(
    input logic [STATUS_W-1:0] st_in,
    input logic [TX_ERR_W-1:0] tx,
    input logic [RX_ERR_W-1:0] rx,
    input logic [RX_OVF_W-1:0] ovf
  );
    logic [STATUS_W-1:0] st;
    st = st_in;
    if (tx >= TX_BUSOFF_LIMIT) begin
      st[ST_BUSOFF] = 1'b1;
    end else begin
      st[ST_BUSOFF] = 1'b0;
      st[ST_RXWARN] = (rx >= RX_WARN_LIMIT);
      st[ST_RXPASSIVE] = (rx >= RX_PASSIVE_LIMIT);
      st[ST_TXWARN] = (tx >= TX_WARN_LIMIT);
      st[ST_TXPASSIVE] = (tx >= TX_PASSIVE_LIMIT);
      if (!st[ST_TXPASSIVE]) st[ST_TXOVF] = 1'b0;
    end
    if (ovf != '0) st[ST_RXOVF] = 1'b1;
    return st;
  endfunction

  assign err_word  = {item_r.tx_error_count, item_r.rx_error_count, item_r.rx_overflow_count};
  assign item_addr = SCAN_W'(item_r.buffer_index);
  assign scan_last = (scan_r == SCAN_W'(NUM_TX_BUFFERS - 1));
  assign rd_addr   = (state_r == S_SCAN) ? scan_r : item_addr;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN) && res_free;

  always_comb begin
    res.transmit_valid = tvalid_r;
    res.transmit_index = tidx_r;
    res.send_overflow  = sovf_r;
    res.error_status   = status_r;
    res.pending_count  = q_cnt_r;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    idx_ok_nxt   = idx_ok_r;
    scan_nxt     = scan_r;
    q_cnt_nxt    = q_cnt_r;
    inhibit_nxt  = inhibit_r;
    await_nxt    = await_r;
    status_nxt   = status_r;
    last_err_nxt = last_err_r;
    tvalid_nxt   = tvalid_r;
    tidx_nxt     = tidx_r;
    sovf_nxt     = sovf_r;
    wr           = '0;
    wr.addr      = rd_addr;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_item;
          idx_ok_nxt = (int'(in_item.buffer_index) < NUM_TX_BUFFERS);
          tvalid_nxt = 1'b0;
          tidx_nxt   = '0;
          sovf_nxt   = 1'b0;
          scan_nxt   = '0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (item_r.opcode)
          OP_SETUP: begin
            if (idx_ok_r) begin
              wr.full_we = 1'b1;
              wr.full    = 1'b0;
              wr.sync_we = 1'b1;
              wr.sync    = item_r.sync_flag;
            end
          end
          OP_SEND: begin
            if (idx_ok_r) begin
              if (rd.full) begin
                sovf_nxt = 1'b1;
                if (!await_r) status_nxt[ST_TXOVF] = 1'b1;
              end
              if (q_cnt_r == '0) begin
                inhibit_nxt = rd.sync;
                tvalid_nxt  = 1'b1;
                tidx_nxt    = item_r.buffer_index;
              end else begin
                wr.full_we = 1'b1;
                wr.full    = 1'b1;
                if (q_cnt_r != COUNT_MAX) q_cnt_nxt = q_cnt_r + COUNT_W'(1);
              end
            end
          end
          OP_TX_DONE: begin
            await_nxt   = 1'b0;
            inhibit_nxt = 1'b0;
            if (q_cnt_r != '0) state_nxt = S_SCAN;
          end
          OP_CLR_SYNC: begin
            // a frame in flight that was a sync pdo counts as dropped
            inhibit_nxt = 1'b0;
            if (inhibit_r) status_nxt[ST_PDOLATE] = 1'b1;
            if (q_cnt_r != '0) state_nxt = S_SCAN;
          end
          OP_ERR_UPD: begin
            if (err_word != last_err_r) begin
              last_err_nxt = err_word;
              status_nxt   = err_status(status_r, item_r.tx_error_count,
                                        item_r.rx_error_count, item_r.rx_overflow_count);
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // one flag pair per cycle through the shared read port
        scan_nxt = scan_r + SCAN_W'(1);
        if (item_r.opcode == OP_TX_DONE) begin
          if (rd.full) begin
            wr.full_we  = 1'b1;
            wr.full     = 1'b0;
            q_cnt_nxt   = q_cnt_r - COUNT_W'(1);
            inhibit_nxt = rd.sync;
            tvalid_nxt  = 1'b1;
            tidx_nxt    = BUF_IDX_W'(scan_r);
            state_nxt   = S_FIN;
          end else if (scan_last) begin
            q_cnt_nxt = '0;
            state_nxt = S_FIN;
          end
        end else begin
          if (rd.full && rd.sync) begin
            wr.full_we = 1'b1;
            wr.full    = 1'b0;
            if (q_cnt_r != '0) q_cnt_nxt = q_cnt_r - COUNT_W'(1);
            status_nxt[ST_PDOLATE] = 1'b1;
          end
          if (scan_last) state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (res_free) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      q_cnt_r    <= '0;
      inhibit_r  <= 1'b0;
      await_r    <= 1'b1;
      status_r   <= '0;
      last_err_r <= '0;
    end else begin
      state_r    <= state_nxt;
      q_cnt_r    <= q_cnt_nxt;
      inhibit_r  <= inhibit_nxt;
      await_r    <= await_nxt;
      status_r   <= status_nxt;
      last_err_r <= last_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    idx_ok_r <= idx_ok_nxt;
    scan_r   <= scan_nxt;
    tvalid_r <= tvalid_nxt;
    tidx_r   <= tidx_nxt;
    sovf_r   <= sovf_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/can_tx_buffer_scheduler_top.sv @@
`default_nettype none
// channel   dir  handshake      payload
// in_bus    in   valid/ready    opcode, buffer_index, sync_flag, tx/rx error counts, rx overflow
// out_bus   out  valid/ready    transmit_valid/index, send_overflow, error_status, pending_count
//
// setup, send, error update and unknown opcodes pass through S_EXEC and S_FIN back to idle
// transmit complete and clear sync with pending buffers add a scan of up to NUM_TX_BUFFERS
// buffers, one buffer per cycle through the single flag read port
// reset (rst_n low, synchronous) clears all flags and counters and leaves in_bus ready
// a result waits in the output register; the next item is accepted meanwhile and
// its own result is held back until out_bus takes the waiting beat
module can_tx_buffer_scheduler_top import ctbs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ctbs_in_if.sink     in_bus,
  ctbs_out_if.source  out_bus
);

  in_item_t          in_item;
  result_t           res;
  result_t           out_r;
  logic              out_valid_r, out_valid_nxt;
  logic              res_valid;
  logic              res_free;
  logic              in_ready;
  logic [SCAN_W-1:0] rd_addr;
  flag_rd_t          rd;
  flag_wr_t          wr;

  always_comb begin
    in_item.opcode            = in_bus.opcode;
    in_item.buffer_index      = in_bus.buffer_index;
    in_item.sync_flag         = in_bus.sync_flag;
    in_item.tx_error_count    = in_bus.tx_error_count;
    in_item.rx_error_count    = in_bus.rx_error_count;
    in_item.rx_overflow_count = in_bus.rx_overflow_count;
  end

  assign in_bus.ready = in_ready;

  ctbs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .res_free (res_free),
    .res_valid(res_valid),
    .res      (res),
    .rd_addr  (rd_addr),
    .rd       (rd),
    .wr       (wr)
  );

  ctbs_flags u_flags (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(rd_addr),
    .rd     (rd),
    .wr     (wr)
  );

  // output register frees up in the same cycle its beat is taken
  assign res_free = !out_valid_r || out_bus.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_r <= res;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.transmit_valid = out_r.transmit_valid;
  assign out_bus.transmit_index = out_r.transmit_index;
  assign out_bus.send_overflow  = out_r.send_overflow;
  assign out_bus.error_status   = out_r.error_status;
  assign out_bus.pending_count  = out_r.pending_count;

endmodule
`default_nettype wire

@@ rtl/ctbs_checker.sv @@
`default_nettype none
module ctbs_checker import ctbs_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 transmit_valid,
  input wire logic [BUF_IDX_W-1:0] transmit_index,
  input wire logic [STATUS_W-1:0]  error_status,
  input wire logic [COUNT_W-1:0]   pending_count
);

  // a waiting beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(error_status) &&
      $stable(pending_count) && $stable(transmit_index))
    else $error("output beat changed while stalled");

  // one item at a time: the input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !transmit_valid |-> transmit_index == '0)
    else $error("transmit index set without a transmit");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind can_tx_buffer_scheduler_top ctbs_checker u_ctbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .transmit_valid(out_bus.transmit_valid),
  .transmit_index(out_bus.transmit_index),
  .error_status  (out_bus.error_status),
  .pending_count (out_bus.pending_count)
);
`default_nettype wire
